// ===== rtl/mfpr_pkg.sv =====
// Shared types and constants for the FIFO page-replacement MMU.
// No dependencies; imported by mfpr_div and the top level.
package mfpr_pkg;

  // Fixed sizes of the translation tables and address fields
  localparam int MAX_PAGES     = 256;
  localparam int MAX_FRAMES    = 64;
  localparam int MAX_PAGE_SIZE = 4096;

  localparam int VA_W    = 20;  // virtual address
  localparam int PA_W    = 18;  // physical address
  localparam int PS_W    = 13;  // page size register
  localparam int PGCNT_W = 9;   // page count register
  localparam int FRCNT_W = 7;   // frame count register / frames handed out
  localparam int OFF_W   = 12;  // page offset
  localparam int PAGE_W  = 8;   // page number
  localparam int FRAME_W = 6;   // frame number
  localparam int PROD_W  = FRAME_W + PS_W;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES     = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_LOOK,
    ST_OWN,
    ST_VDRT,
    ST_MUL,
    ST_DONE
  } state_t;

  // Page table entry; residency lives in flip-flops beside the RAM
  typedef struct packed {
    logic               dirty;
    logic [FRAME_W-1:0] frame;
  } pt_entry_t;

  // Divider result, valid while done is high
  typedef struct packed {
    logic             done;
    logic [VA_W-1:0]  quot;
    logic [OFF_W-1:0] rem;
  } div_res_t;

endpackage

// ===== rtl/mfpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the page table and the frame owner table.
module mfpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mfpr_div.sv =====
// Restoring divider, one quotient bit per cycle, splits an address into
// page number and offset. Depends on mfpr_pkg.
module mfpr_div
  import mfpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [VA_W-1:0]   dividend,
  input  logic [PS_W-1:0]   divisor,
  output div_res_t          res
);

  localparam int CNT_W = $clog2(VA_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [VA_W-1:0]  quot;
  logic [OFF_W-1:0] rem;
  logic [PS_W-1:0]  trial;
  logic [PS_W-1:0]  diff;
  logic             ge;

  // one subtract-and-compare step
  assign trial = {rem, quot[VA_W-1]};
  assign ge    = trial >= divisor;
  assign diff  = trial - divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(VA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out on top, quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[VA_W-2:0], ge};
      rem  <= ge ? diff[OFF_W-1:0] : trial[OFF_W-1:0];
    end
  end

  assign res.done = done;
  assign res.quot = quot;
  assign res.rem  = rem;

endmodule

// ===== rtl/mmu_fifo_page_replacement_top.sv =====
// Demand-paging MMU with FIFO frame replacement, top level.
// An access runs from acceptance through the 20-step divider, range check, table lookup and multiply
// to the result; an eviction adds the owner read and victim update, an illegal page goes to the result.
// A new access word is taken only in idle, so in_stall holds the next off until the result is out.
// Reset clears residency bits, frame counters and configuration (defaults 4096/256/64);
// table RAMs are not cleared, there is no clearing pass.
module mmu_fifo_page_replacement_top
  import mfpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PS_W-1:0]      cfg_data,
  // access words
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 req_type,
  input  logic [VA_W-1:0]      vaddr,
  // result words
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PA_W-1:0]      phys_addr,
  output logic                 illegal,
  output logic                 fault,
  output logic [FRAME_W-1:0]   frame_used,
  output logic                 evicted,
  output logic [PAGE_W-1:0]    evicted_page,
  output logic                 writeback
);

  state_t state, state_next;

  // configuration registers
  logic [PS_W-1:0]    page_size;
  logic [PGCNT_W-1:0] pages_in_use;
  logic [FRCNT_W-1:0] frames_in_use;
  logic [PS_W-1:0]    eff_ps;
  logic [PGCNT_W-1:0] eff_pages;
  logic [FRCNT_W-1:0] eff_frames;

  // replacement state
  logic               present [MAX_PAGES];
  logic [FRCNT_W-1:0] frames_taken;
  logic [FRAME_W-1:0] fifo_victim;

  // per-access working registers
  logic               is_write;
  logic [VA_W-1:0]    page_q;
  logic [OFF_W-1:0]   offset;
  logic [FRAME_W-1:0] frame_r;
  logic               fault_r;
  logic               ev_r;
  logic [PAGE_W-1:0]  ev_page_r;
  logic               wb_r;
  logic               illegal_r;
  logic [PROD_W-1:0]  prod;

  logic               in_acc;
  logic               out_free;
  logic [PAGE_W-1:0]  pg;
  logic               hit;
  logic               free_ok;
  logic [FRAME_W-1:0] vf;
  logic [FRCNT_W-1:0] frame_inc;
  logic [VA_W:0]      phys_sum;

  // table ports
  logic               pt_we;
  logic [PAGE_W-1:0]  pt_waddr;
  pt_entry_t          pt_wdata;
  logic [PAGE_W-1:0]  pt_raddr;
  pt_entry_t          pt_rdata;
  logic               own_we;
  logic [FRAME_W-1:0] own_waddr;
  logic [FRAME_W-1:0] own_raddr;
  logic [PAGE_W-1:0]  own_rdata;

  div_res_t           div_res;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // effective configuration with out-of-range values folded in
  always_comb begin
    if (page_size == '0) begin
      eff_ps = PS_W'(1);
    end else if (page_size > PS_W'(MAX_PAGE_SIZE)) begin
      eff_ps = PS_W'(MAX_PAGE_SIZE);
    end else begin
      eff_ps = page_size;
    end
    eff_pages = (pages_in_use > PGCNT_W'(MAX_PAGES)) ? PGCNT_W'(MAX_PAGES) : pages_in_use;
    if (frames_in_use == '0) begin
      eff_frames = FRCNT_W'(1);
    end else if (frames_in_use > FRCNT_W'(MAX_FRAMES)) begin
      eff_frames = FRCNT_W'(MAX_FRAMES);
    end else begin
      eff_frames = frames_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size     <= PS_W'(MAX_PAGE_SIZE);
      pages_in_use  <= PGCNT_W'(MAX_PAGES);
      frames_in_use <= FRCNT_W'(MAX_FRAMES);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAGE_SIZE: page_size     <= cfg_data;
        CFG_PAGES:     pages_in_use  <= cfg_data[PGCNT_W-1:0];
        CFG_FRAMES:    frames_in_use <= cfg_data[FRCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // divider: page = va / size, offset = va % size
  mfpr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (in_acc),
    .dividend (vaddr),
    .divisor  (eff_ps),
    .res      (div_res)
  );

  // page table: dirty bit and frame per page
  mfpr_ram #(
    .WIDTH ($bits(pt_entry_t)),
    .DEPTH (MAX_PAGES)
  ) u_page_table (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  // owner page of each frame
  mfpr_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (MAX_FRAMES)
  ) u_frame_owner (
    .clk   (clk),
    .we    (own_we),
    .waddr (own_waddr),
    .wdata (pg),
    .raddr (own_raddr),
    .rdata (own_rdata)
  );

  // lookup helpers
  assign pg        = page_q[PAGE_W-1:0];
  assign hit       = present[pg];
  assign free_ok   = frames_taken < eff_frames;
  assign vf        = ({1'b0, fifo_victim} >= frames_taken) ? '0 : fifo_victim;
  assign frame_inc = {1'b0, frame_r} + 1'b1;
  assign phys_sum  = (VA_W + 1)'(prod) + (VA_W + 1)'(offset);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_acc) state_next = ST_DIV;
      ST_DIV:   if (div_res.done) state_next = ST_CHECK;
      ST_CHECK: begin
        if (page_q >= VA_W'(eff_pages)) state_next = ST_DONE;
        else                            state_next = ST_LOOK;
      end
      ST_LOOK: begin
        if (hit || free_ok) state_next = ST_MUL;
        else                state_next = ST_OWN;
      end
      ST_OWN:   state_next = ST_VDRT;
      ST_VDRT:  state_next = ST_MUL;
      ST_MUL:   state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // table strobes
  always_comb begin
    pt_we     = 1'b0;
    pt_waddr  = pg;
    pt_wdata  = '{dirty: is_write, frame: frame_r};
    pt_raddr  = pg;
    own_we    = 1'b0;
    own_waddr = frame_r;
    own_raddr = vf;
    unique case (state)
      ST_LOOK: begin
        if (hit) begin
          pt_we    = is_write;
          pt_wdata = '{dirty: 1'b1, frame: pt_rdata.frame};
        end else if (free_ok) begin
          pt_we     = 1'b1;
          pt_wdata  = '{dirty: is_write, frame: frames_taken[FRAME_W-1:0]};
          own_we    = 1'b1;
          own_waddr = frames_taken[FRAME_W-1:0];
        end
      end
      ST_OWN:  pt_raddr = own_rdata;
      ST_VDRT: begin
        pt_we  = 1'b1;
        own_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // residency bits and FIFO pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PAGES; i++) present[i] <= 1'b0;
      frames_taken <= '0;
      fifo_victim  <= '0;
    end else begin
      if (state == ST_LOOK && !hit && free_ok) begin
        present[pg]  <= 1'b1;
        frames_taken <= frames_taken + 1'b1;
      end
      if (state == ST_VDRT) begin
        present[ev_page_r] <= 1'b0;
        present[pg]        <= 1'b1;
        fifo_victim <= (frame_inc >= frames_taken) ? '0 : frame_inc[FRAME_W-1:0];
      end
    end
  end

  // per-access datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      is_write  <= req_type;
      frame_r   <= '0;
      fault_r   <= 1'b0;
      ev_r      <= 1'b0;
      ev_page_r <= '0;
      wb_r      <= 1'b0;
      illegal_r <= 1'b0;
    end
    if (state == ST_DIV && div_res.done) begin
      page_q <= div_res.quot;
      offset <= div_res.rem;
    end
    if (state == ST_CHECK && page_q >= VA_W'(eff_pages)) begin
      illegal_r <= 1'b1;
    end
    if (state == ST_LOOK) begin
      if (hit) begin
        frame_r <= pt_rdata.frame;
      end else if (free_ok) begin
        frame_r <= frames_taken[FRAME_W-1:0];
        fault_r <= 1'b1;
      end else begin
        frame_r <= vf;
        fault_r <= 1'b1;
        ev_r    <= 1'b1;
      end
    end
    if (state == ST_OWN) begin
      ev_page_r <= own_rdata;
    end
    if (state == ST_VDRT) begin
      wb_r <= present[ev_page_r] && pt_rdata.dirty;
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(frame_r) * PROD_W'(eff_ps);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      phys_addr    <= illegal_r ? '0 : phys_sum[PA_W-1:0];
      illegal      <= illegal_r;
      fault        <= fault_r;
      frame_used   <= frame_r;
      evicted      <= ev_r;
      evicted_page <= ev_page_r;
      writeback    <= wb_r;
    end
  end

  // checks
  a_frames_bound: assert property (@(posedge clk) disable iff (rst)
    frames_taken <= FRCNT_W'(MAX_FRAMES))
    else $error("frames handed out exceed frame table");

  a_fifo_in_range: assert property (@(posedge clk) disable iff (rst)
    fifo_victim == '0 || {1'b0, fifo_victim} < frames_taken)
    else $error("FIFO pointer beyond frames handed out");

  a_evict_is_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && (evicted || writeback) |-> fault && evicted)
    else $error("eviction flags without a fault");

  a_illegal_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && illegal |-> !fault && !evicted && phys_addr == '0)
    else $error("illegal access carries translation");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_valid && out_stall |=> state == ST_DONE && $stable(phys_addr))
    else $error("pending result overwritten");

endmodule
